// ===== hw/rtl/tfdm_pkg.sv =====
// Shared types and constants for the triple feedback delay mix.
// Holds the configuration word layout, register indexes, mix weights and the
// sequencer state type. Depends on nothing.
`default_nettype none

package tfdm_pkg;

  // Default sizing of the delay lines and the sample word.
  localparam int unsigned MAX_DELAY_DEF   = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned WET_W      = 17;
  localparam int unsigned FB_W       = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_CENTRE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN      = 3'd4;

  // Register reset values.
  localparam logic [DELAY_W-1:0] RST_DELAY_LEFT   = 16'd14400;
  localparam logic [DELAY_W-1:0] RST_DELAY_CENTRE = 16'd38400;
  localparam logic [DELAY_W-1:0] RST_DELAY_RIGHT  = 16'd21600;
  localparam logic [WET_W-1:0]   RST_WET_GAIN     = 17'd0;
  localparam logic [FB_W-1:0]    RST_FB_GAIN      = 16'd0;

  // Pan weights in unsigned Q0.16: 0.85, 0.5 and 0.15.
  localparam logic [15:0] MIX_W_HI  = 16'd55706;
  localparam logic [15:0] MIX_W_MID = 16'd32768;
  localparam logic [15:0] MIX_W_LO  = 16'd9830;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_left;
    logic [DELAY_W-1:0] delay_centre;
    logic [DELAY_W-1:0] delay_right;
    logic [WET_W-1:0]   wet_gain;
    logic [FB_W-1:0]    feedback_gain;
  } cfg_t;

  // Per-step controls from the sequencer to each delay line.
  typedef struct packed {
    logic rd_en;    // issue the tap read
    logic prod_en;  // capture tap times feedback gain
    logic wr_en;    // write the line entry
    logic clear;    // write zero instead of the feedback sum
  } line_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfdm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read and a write of the same address in one cycle return the old data.
// Depends on nothing.
`default_nettype none

module tfdm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tfdm_cfg.sv =====
// Configuration register file of the triple feedback delay mix.
// Decodes register writes by index; writes to unknown indexes are dropped.
// Depends on tfdm_pkg.
`default_nettype none

module tfdm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [tfdm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [tfdm_pkg::CFG_DATA_W-1:0]  wr_data,
  output tfdm_pkg::cfg_t                        cfg
);

  import tfdm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_left    <= RST_DELAY_LEFT;
      cfg_r.delay_centre  <= RST_DELAY_CENTRE;
      cfg_r.delay_right   <= RST_DELAY_RIGHT;
      cfg_r.wet_gain      <= RST_WET_GAIN;
      cfg_r.feedback_gain <= RST_FB_GAIN;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DELAY_LEFT:   cfg_r.delay_left    <= wr_data[DELAY_W-1:0];
        REG_DELAY_CENTRE: cfg_r.delay_centre  <= wr_data[DELAY_W-1:0];
        REG_DELAY_RIGHT:  cfg_r.delay_right   <= wr_data[DELAY_W-1:0];
        REG_WET_GAIN:     cfg_r.wet_gain      <= wr_data[WET_W-1:0];
        REG_FB_GAIN:      cfg_r.feedback_gain <= wr_data[FB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tfdm_line.sv =====
// One circular delay line: RAM, feedback multiplier and saturating write-back.
// The write value is mono plus the rounded tap times feedback gain.
// Depends on tfdm_pkg and tfdm_ram.
`default_nettype none

module tfdm_line #(
  parameter int unsigned MAX_DELAY   = tfdm_pkg::MAX_DELAY_DEF,
  parameter int unsigned SAMPLE_BITS = tfdm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire tfdm_pkg::line_ctl_t               ctl,
  input  wire logic [$clog2(MAX_DELAY)-1:0]      rd_addr,
  input  wire logic [$clog2(MAX_DELAY)-1:0]      wr_addr,
  input  wire logic [tfdm_pkg::FB_W-1:0]         fb_gain,
  input  wire logic signed [SAMPLE_BITS-1:0]     mono,
  output logic signed [SAMPLE_BITS-1:0]          tap
);

  import tfdm_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned PW = SB + 17;  // tap times 17-bit signed gain
  localparam int unsigned AW = SB + 2;   // mono plus feedback term
  localparam logic signed [AW-1:0] SAT_HI = $signed({{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}});
  localparam logic signed [AW-1:0] SAT_LO = $signed({{(AW-SB+1){1'b1}}, {(SB-1){1'b0}}});

  logic [SB-1:0]        rd_data;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_rnd;
  logic signed [SB:0]   fb_term;
  logic signed [AW-1:0] wr_sum;
  logic signed [SB-1:0] wr_sat;
  logic [SB-1:0]        wr_data;

  tfdm_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_DELAY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ctl.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (ctl.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign tap = $signed(rd_data);

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= tap * $signed({1'b0, fb_gain});
    end
  end

  // Round half up, then drop the 16 fraction bits.
  assign prod_rnd = prod_r + $signed(PW'(32768));
  assign fb_term  = prod_rnd[PW-1:16];
  assign wr_sum   = $signed({{2{mono[SB-1]}}, mono}) + $signed({fb_term[SB], fb_term});

  always_comb begin
    if (wr_sum > SAT_HI) begin
      wr_sat = SAT_HI[SB-1:0];
    end else if (wr_sum < SAT_LO) begin
      wr_sat = SAT_LO[SB-1:0];
    end else begin
      wr_sat = wr_sum[SB-1:0];
    end
  end

  assign wr_data = ctl.clear ? '0 : wr_sat;

endmodule

`default_nettype wire

// ===== hw/rtl/triple_feedback_delay_mix.sv =====
// Stereo delay with three feedback lines (left, centre, right) and dry/wet mix.
// Depends on tfdm_pkg, tfdm_cfg, tfdm_line and tfdm_ram.
//
// Usage:
//   Input words carry a stereo pair (in_left, in_right) and are taken at a
//   clock edge where in_valid is high and in_stall is low. Each input word
//   yields exactly one output word (out_left, out_right), offered on out_valid
//   and held until a cycle with out_stall low.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Change registers only while the block is idle.
// Timing:
//   The block takes one word at a time: accept and tap read, RAM data and
//   multiplies, line write-back. The RAM read latency and the write of the
//   same step set this pace. The word then passes the mix, wet product and
//   output registers. Behind a stalled output, two words wait in the wet
//   and mix stages and a third in the line write stage; then input stalls.
// Reset:
//   rst_n is synchronous. After reset the three lines are cleared one entry
//   per cycle over all entries, with in_stall high; then the block is idle.
// MAX_DELAY must be a power of two; delays wrap modulo MAX_DELAY, and a delay
// of zero returns the entry written MAX_DELAY words earlier.
`default_nettype none

module triple_feedback_delay_mix #(
  parameter int unsigned MAX_DELAY   = tfdm_pkg::MAX_DELAY_DEF,
  parameter int unsigned SAMPLE_BITS = tfdm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_left,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_right,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]          out_left,
  output logic signed [SAMPLE_BITS-1:0]          out_right,
  // Configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tfdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tfdm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import tfdm_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned AW = $clog2(MAX_DELAY);
  localparam int unsigned PW = SB + 17;  // tap times a pan weight
  localparam int unsigned SW = SB + 19;  // sum of three weighted taps
  localparam int unsigned MW = SB + 3;   // rounded mix
  localparam int unsigned XW = MW + 18;  // mix times wet gain
  localparam int unsigned RW = XW - 16;  // rounded wet term
  localparam int unsigned OW = RW + 1;   // dry plus wet
  localparam logic signed [OW-1:0] SAT_HI = $signed({{(OW-SB+1){1'b0}}, {(SB-1){1'b1}}});
  localparam logic signed [OW-1:0] SAT_LO = $signed({{(OW-SB+1){1'b1}}, {(SB-1){1'b0}}});
  localparam logic signed [16:0] WT_HI  = $signed({1'b0, MIX_W_HI});
  localparam logic signed [16:0] WT_MID = $signed({1'b0, MIX_W_MID});
  localparam logic signed [16:0] WT_LO  = $signed({1'b0, MIX_W_LO});

  cfg_t      cfg;
  line_ctl_t line_ctl;
  state_t    state_r, state_nxt;

  logic [AW-1:0] wp_r, wp_nxt;
  logic          accept;
  logic          front_go;

  // Front-end payload of the word in flight.
  logic signed [SB-1:0] dry_left_r, dry_right_r, mono_r;
  logic signed [SB:0]   pair_sum;

  logic [AW-1:0] rd_addr_left, rd_addr_centre, rd_addr_right;
  logic signed [SB-1:0] tap_left, tap_centre, tap_right;

  // Weighted taps; the centre weight is shared by both sides.
  logic signed [PW-1:0] lh_r, ll_r, cm_r, rh_r, rl_r;
  logic signed [SW-1:0] mix_sum_left, mix_sum_right;

  // Mix stage.
  logic                 mix_vld_r;
  logic signed [MW-1:0] mix_left_r, mix_right_r;
  logic signed [SB-1:0] mix_dry_left_r, mix_dry_right_r;
  // Wet product stage.
  logic                 wet_vld_r;
  logic signed [XW-1:0] wet_left_r, wet_right_r;
  logic signed [SB-1:0] wet_dry_left_r, wet_dry_right_r;
  // Output register.
  logic                 out_valid_r;
  logic signed [SB-1:0] out_left_r, out_right_r;

  logic out_free, wet_go, wet_free, mix_go, mix_free;
  logic signed [XW-1:0] wet_rnd_left, wet_rnd_right;
  logic signed [OW-1:0] out_sum_left, out_sum_right;
  logic signed [SB-1:0] out_sat_left, out_sat_right;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  tfdm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_index(cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: clear sweep after reset, then read, multiply and write back
  // one word at a time. The write of a word lands before the next word's
  // read is issued, so a delay of one sees the newest entry without bypass.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      wp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    line_ctl  = '0;
    in_stall  = 1'b1;
    accept    = 1'b0;
    front_go  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        // The write pointer doubles as the sweep address and wraps to zero.
        line_ctl.wr_en = 1'b1;
        line_ctl.clear = 1'b1;
        wp_nxt         = wp_r + 1'b1;
        if (wp_r == {AW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          accept         = 1'b1;
          line_ctl.rd_en = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        line_ctl.prod_en = 1'b1;
        state_nxt        = ST_WRITE;
      end
      ST_WRITE: begin
        // Hold here until the mix stage can take the word.
        if (mix_free) begin
          front_go       = 1'b1;
          line_ctl.wr_en = 1'b1;
          wp_nxt         = wp_r + 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Mono is the floor of the pair's average.
  assign pair_sum = $signed({in_left[SB-1], in_left}) + $signed({in_right[SB-1], in_right});

  always_ff @(posedge clk) begin
    if (accept) begin
      dry_left_r  <= in_left;
      dry_right_r <= in_right;
      mono_r      <= pair_sum[SB:1];
    end
  end

  // Taps sit a delay behind the write pointer, modulo the ring size.
  assign rd_addr_left   = wp_r - AW'(cfg.delay_left);
  assign rd_addr_centre = wp_r - AW'(cfg.delay_centre);
  assign rd_addr_right  = wp_r - AW'(cfg.delay_right);

  // ---------------------------------------------------------------------------
  // Delay lines
  // ---------------------------------------------------------------------------
  tfdm_line #(
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_line_left (
    .clk    (clk),
    .ctl    (line_ctl),
    .rd_addr(rd_addr_left),
    .wr_addr(wp_r),
    .fb_gain(cfg.feedback_gain),
    .mono   (mono_r),
    .tap    (tap_left)
  );

  tfdm_line #(
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_line_centre (
    .clk    (clk),
    .ctl    (line_ctl),
    .rd_addr(rd_addr_centre),
    .wr_addr(wp_r),
    .fb_gain(cfg.feedback_gain),
    .mono   (mono_r),
    .tap    (tap_centre)
  );

  tfdm_line #(
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_line_right (
    .clk    (clk),
    .ctl    (line_ctl),
    .rd_addr(rd_addr_right),
    .wr_addr(wp_r),
    .fb_gain(cfg.feedback_gain),
    .mono   (mono_r),
    .tap    (tap_right)
  );

  // ---------------------------------------------------------------------------
  // Pan mix: weighted taps are captured with the feedback products, then
  // summed and rounded as the lines are written back.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (line_ctl.prod_en) begin
      lh_r <= tap_left * WT_HI;
      ll_r <= tap_left * WT_LO;
      cm_r <= tap_centre * WT_MID;
      rh_r <= tap_right * WT_HI;
      rl_r <= tap_right * WT_LO;
    end
  end

  assign mix_sum_left  = SW'(lh_r) + SW'(cm_r) + SW'(rl_r) + $signed(SW'(32768));
  assign mix_sum_right = SW'(ll_r) + SW'(cm_r) + SW'(rh_r) + $signed(SW'(32768));

  // ---------------------------------------------------------------------------
  // Back end: mix, wet product and output register, each with a valid bit so
  // that a stalled receiver backs the words up stage by stage.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign wet_go   = wet_vld_r && out_free;
  assign wet_free = !wet_vld_r || wet_go;
  assign mix_go   = mix_vld_r && wet_free;
  assign mix_free = !mix_vld_r || mix_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_vld_r   <= 1'b0;
      wet_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (front_go) begin
        mix_vld_r <= 1'b1;
      end else if (mix_go) begin
        mix_vld_r <= 1'b0;
      end
      if (mix_go) begin
        wet_vld_r <= 1'b1;
      end else if (wet_go) begin
        wet_vld_r <= 1'b0;
      end
      if (wet_go) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_go) begin
      mix_left_r      <= mix_sum_left[SW-1:16];
      mix_right_r     <= mix_sum_right[SW-1:16];
      mix_dry_left_r  <= dry_left_r;
      mix_dry_right_r <= dry_right_r;
    end
    if (mix_go) begin
      wet_left_r      <= mix_left_r * $signed({1'b0, cfg.wet_gain});
      wet_right_r     <= mix_right_r * $signed({1'b0, cfg.wet_gain});
      wet_dry_left_r  <= mix_dry_left_r;
      wet_dry_right_r <= mix_dry_right_r;
    end
    if (wet_go) begin
      out_left_r  <= out_sat_left;
      out_right_r <= out_sat_right;
    end
  end

  assign wet_rnd_left  = wet_left_r + $signed(XW'(32768));
  assign wet_rnd_right = wet_right_r + $signed(XW'(32768));

  assign out_sum_left  = $signed({{(OW-SB){wet_dry_left_r[SB-1]}}, wet_dry_left_r})
                       + $signed({wet_rnd_left[XW-1], wet_rnd_left[XW-1:16]});
  assign out_sum_right = $signed({{(OW-SB){wet_dry_right_r[SB-1]}}, wet_dry_right_r})
                       + $signed({wet_rnd_right[XW-1], wet_rnd_right[XW-1:16]});

  always_comb begin
    if (out_sum_left > SAT_HI) begin
      out_sat_left = SAT_HI[SB-1:0];
    end else if (out_sum_left < SAT_LO) begin
      out_sat_left = SAT_LO[SB-1:0];
    end else begin
      out_sat_left = out_sum_left[SB-1:0];
    end
    if (out_sum_right > SAT_HI) begin
      out_sat_right = SAT_HI[SB-1:0];
    end else if (out_sum_right < SAT_LO) begin
      out_sat_right = SAT_LO[SB-1:0];
    end else begin
      out_sat_right = out_sum_right[SB-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tfdm_chk.sv =====
// Port-level checker for the triple feedback delay mix, bound to the top level.
// Watches the input, result and configuration handshakes over time.
// Depends on tfdm_pkg.
`default_nettype none

module tfdm_chk #(
  parameter int unsigned SAMPLE_BITS = tfdm_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [SAMPLE_BITS-1:0] out_left,
  input wire logic signed [SAMPLE_BITS-1:0] out_right,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready
);

  import tfdm_pkg::*;

  // A stalled output word stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("output word changed while stalled");

  // Words are processed one at a time: an accepted word blocks the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // The clearing sweep after reset keeps the input closed.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // Register writes are never back-pressured.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind triple_feedback_delay_mix tfdm_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_tfdm_chk (.*);

`default_nettype wire
